// ===== hdl/grs_pkg.sv =====
// Shared types and constants of the greedy route splitter.
`timescale 1ns / 1ps
`default_nettype none

package grs_pkg;

  // Fixed field widths of the item and result channels.
  localparam int NODE_ID_BITS = 6;
  localparam int WEIGHT_BITS  = 16;
  localparam int LOAD_BITS    = 16;
  localparam int COST_BITS    = 32;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS = 2;

  // Result queue: one tour item gives at most four results.
  localparam int RES_SLOTS     = 4;
  localparam int SLOT_CNT_BITS = 3;
  localparam int FIFO_DEPTH    = 16;
  localparam int FIFO_PTR_BITS = 4;
  localparam int FIFO_CNT_BITS = 5;

  // Register values after reset.
  localparam logic [NODE_ID_BITS-1:0] DEPOT_RESET      = 6'd0;
  localparam logic [LOAD_BITS-1:0]    CAPACITY_RESET   = 16'd10;
  localparam logic [COST_BITS-1:0]    PATH_LIMIT_RESET = 32'd80000;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_DIST   = 2'd0,
    OP_DEMAND = 2'd1,
    OP_TOUR   = 2'd2
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DEPOT      = 2'd0,
    CFG_CAPACITY   = 2'd1,
    CFG_PATH_LIMIT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [NODE_ID_BITS-1:0] depot;
    logic [LOAD_BITS-1:0]    capacity;
    logic [COST_BITS-1:0]    path_limit;
  } cfg_t;

  typedef struct packed {
    logic [NODE_ID_BITS-1:0] node;
    logic                    last;
    logic [COST_BITS-1:0]    cost;
    logic                    sat;
  } result_t;

  // Results of one tour item, in emission order, with a mask of the used slots.
  typedef struct packed {
    logic [RES_SLOTS-1:0]  mask;
    result_t [RES_SLOTS-1:0] slot;
  } push_grp_t;

  typedef struct packed {
    logic busy;       // second read pair of a tour item is being issued
    logic finishing;  // a tour item is being completed this cycle
  } core_status_t;

endpackage

`default_nettype wire

// ===== hdl/grs_dist_mem.sv =====
// Distance table: synchronous memory with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module grs_dist_mem #(
  parameter int ADDR_BITS = 12,
  parameter int DATA_BITS = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr_a,
  input  logic [ADDR_BITS-1:0] raddr_b,
  output logic [DATA_BITS-1:0] rdata_a,
  output logic [DATA_BITS-1:0] rdata_b
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [DATA_BITS-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== hdl/grs_split_core.sv =====
// Split core: table writes, the two-phase table lookup and the route decision per tour node.
`timescale 1ns / 1ps
`default_nettype none

module grs_split_core import grs_pkg::*; #(
  parameter int NODE_COUNT = 64,
  parameter int DIST_BITS  = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    in_acc,
  input  logic [1:0]              in_op,
  input  logic [NODE_ID_BITS-1:0] in_node_a,
  input  logic [NODE_ID_BITS-1:0] in_node_b,
  input  logic [WEIGHT_BITS-1:0]  in_weight,
  input  logic                    in_tour_end,
  output core_status_t            status,
  output push_grp_t               push
);

  localparam int NODE_BITS = $clog2(NODE_COUNT);
  localparam int ADDR_BITS = 2 * NODE_BITS;

  function automatic logic node_ok(input logic [NODE_ID_BITS-1:0] id);
    return 32'(id) < 32'(NODE_COUNT);
  endfunction

  // Route and tour state.
  logic                    started_r, started_nxt;
  logic [NODE_ID_BITS-1:0] prev_r, prev_nxt;
  logic [LOAD_BITS-1:0]    load_r, load_nxt;
  logic [COST_BITS-1:0]    len_r, len_nxt;
  logic [COST_BITS-1:0]    cost_r, cost_nxt;
  logic                    sat_r, sat_nxt;

  // Pipeline phase flags.
  logic ph1_r, ph2_r;

  // First-phase item registers.
  logic [NODE_ID_BITS-1:0] s1_a_r, s1_d_r, s1_prev_r;
  logic s1_end_r, s1_start_r, s1_a_is_d_r, s1_a_ok_r, s1_d_ok_r, s1_prev_ok_r;

  // Second-phase item registers.
  logic [NODE_ID_BITS-1:0] s2_a_r, s2_d_r;
  logic s2_end_r, s2_start_r, s2_a_is_d_r, s2_a_ok_r, s2_d_ok_r, s2_prev_ok_r, s2_fit_r;
  logic [LOAD_BITS-1:0]    s2_load_r, s2_dem_r;
  logic [COST_BITS-1:0]    s2_len_r;
  logic [DIST_BITS-1:0]    s2_leg_r, s2_tail_r;

  // Decode of the accepted item.
  logic                    is_tour, is_dist_wr, is_dem_wr, a_is_d_in;
  logic [NODE_ID_BITS-1:0] prev_eff;

  assign is_tour    = in_acc && (in_op == OP_TOUR);
  assign is_dist_wr = in_acc && (in_op == OP_DIST) && node_ok(in_node_a) && node_ok(in_node_b);
  assign is_dem_wr  = in_acc && (in_op == OP_DEMAND) && node_ok(in_node_a);
  assign a_is_d_in  = (in_node_a == cfg.depot);
  assign prev_eff   = started_r ? prev_r : cfg.depot;

  // Read addresses: the first pair at acceptance, the second pair in the next cycle.
  logic [NODE_ID_BITS-1:0] ra_row, ra_col, rb_row, rb_col;
  logic [DIST_BITS-1:0]    rdata_a, rdata_b;

  always_comb begin
    if (ph1_r) begin
      ra_row = s1_prev_r;
      ra_col = s1_d_r;
      rb_row = s1_d_r;
      rb_col = s1_a_r;
    end else begin
      ra_row = prev_eff;
      ra_col = in_node_a;
      rb_row = in_node_a;
      rb_col = cfg.depot;
    end
  end

  grs_dist_mem #(
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (DIST_BITS)
  ) u_dist_mem (
    .clk     (clk),
    .we      (is_dist_wr),
    .waddr   ({NODE_BITS'(in_node_a), NODE_BITS'(in_node_b)}),
    .wdata   (DIST_BITS'(in_weight)),
    .raddr_a ({NODE_BITS'(ra_row), NODE_BITS'(ra_col)}),
    .raddr_b ({NODE_BITS'(rb_row), NODE_BITS'(rb_col)}),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Demand table, read together with the first distance pair.
  logic [LOAD_BITS-1:0] dem_mem [NODE_COUNT];
  logic [LOAD_BITS-1:0] dem_q_r;

  always_ff @(posedge clk) begin
    if (is_dem_wr) begin
      dem_mem[NODE_BITS'(in_node_a)] <= in_weight;
    end
    dem_q_r <= dem_mem[NODE_BITS'(in_node_a)];
  end

  // First-phase capture of the tour item.
  always_ff @(posedge clk) begin
    if (is_tour) begin
      s1_a_r       <= in_node_a;
      s1_d_r       <= cfg.depot;
      s1_prev_r    <= prev_eff;
      s1_end_r     <= in_tour_end;
      s1_start_r   <= ~started_r;
      s1_a_is_d_r  <= a_is_d_in;
      s1_a_ok_r    <= node_ok(in_node_a);
      s1_d_ok_r    <= node_ok(cfg.depot);
      s1_prev_ok_r <= node_ok(prev_eff);
    end
  end

  // Route decision from the leg in, the return leg and the demand.
  logic [DIST_BITS-1:0]  leg, tail;
  logic [LOAD_BITS-1:0]  dem, base_load;
  logic [COST_BITS-1:0]  base_len;
  logic [LOAD_BITS:0]    load_sum;
  logic [COST_BITS:0]    len_sum;
  logic [COST_BITS+1:0]  span;
  logic                  fit;

  always_comb begin
    leg       = (s1_prev_ok_r && s1_a_ok_r) ? rdata_a : '0;
    tail      = (s1_a_ok_r && s1_d_ok_r) ? rdata_b : '0;
    dem       = s1_a_ok_r ? dem_q_r : '0;
    base_load = s1_start_r ? '0 : load_r;
    base_len  = s1_start_r ? '0 : len_r;
    load_sum  = {1'b0, base_load} + {1'b0, dem};
    len_sum   = {1'b0, base_len} + (COST_BITS+1)'(leg);
    span      = {1'b0, len_sum} + (COST_BITS+2)'(tail);
    fit       = (load_sum <= {1'b0, cfg.capacity}) && (span <= {2'b00, cfg.path_limit});
  end

  always_ff @(posedge clk) begin
    if (ph1_r) begin
      s2_a_r       <= s1_a_r;
      s2_d_r       <= s1_d_r;
      s2_end_r     <= s1_end_r;
      s2_start_r   <= s1_start_r;
      s2_a_is_d_r  <= s1_a_is_d_r;
      s2_a_ok_r    <= s1_a_ok_r;
      s2_d_ok_r    <= s1_d_ok_r;
      s2_prev_ok_r <= s1_prev_ok_r;
      s2_fit_r     <= fit;
      s2_load_r    <= load_sum[LOAD_BITS-1:0];
      s2_len_r     <= len_sum[COST_BITS-1:0];
      s2_leg_r     <= leg;
      s2_tail_r    <= tail;
      s2_dem_r     <= dem;
    end
  end

  // Completion: cost update with the split legs and the closing leg.
  logic [DIST_BITS-1:0]  dp_d, dd_a;
  logic [COST_BITS:0]    route_inc;
  logic [COST_BITS-1:0]  end_inc, base_cost, cost_new;
  logic [COST_BITS+1:0]  cost_sum;
  logic                  ovf, sat_new;

  always_comb begin
    dp_d      = (s2_prev_ok_r && s2_d_ok_r) ? rdata_a : '0;
    dd_a      = (s2_d_ok_r && s2_a_ok_r) ? rdata_b : '0;
    if (s2_a_is_d_r) begin
      route_inc = '0;
    end else if (s2_fit_r) begin
      route_inc = (COST_BITS+1)'(s2_leg_r);
    end else begin
      route_inc = (COST_BITS+1)'(dp_d) + (COST_BITS+1)'(dd_a);
    end
    if (!s2_end_r) begin
      end_inc = '0;
    end else if (s2_a_is_d_r) begin
      end_inc = COST_BITS'(dp_d);
    end else begin
      end_inc = COST_BITS'(s2_tail_r);
    end
    base_cost = s2_start_r ? '0 : cost_r;
    cost_sum  = (COST_BITS+2)'(base_cost) + (COST_BITS+2)'(route_inc)
              + (COST_BITS+2)'(end_inc);
    ovf       = |cost_sum[COST_BITS+1:COST_BITS];
    cost_new  = ovf ? '1 : cost_sum[COST_BITS-1:0];
    sat_new   = (sat_r && !s2_start_r) || ovf;
  end

  // Next state of the tour and route registers.
  always_comb begin
    started_nxt = started_r;
    prev_nxt    = prev_r;
    load_nxt    = load_r;
    len_nxt     = len_r;
    cost_nxt    = cost_r;
    sat_nxt     = sat_r;
    if (is_tour) begin
      started_nxt = ~in_tour_end;
      if (in_tour_end) begin
        prev_nxt = cfg.depot;
      end else if (a_is_d_in) begin
        prev_nxt = prev_eff;
      end else begin
        prev_nxt = in_node_a;
      end
    end
    if (ph2_r) begin
      cost_nxt = cost_new;
      sat_nxt  = sat_new;
      if (s2_a_is_d_r) begin
        load_nxt = s2_start_r ? '0 : load_r;
        len_nxt  = s2_start_r ? '0 : len_r;
      end else if (s2_fit_r) begin
        load_nxt = s2_load_r;
        len_nxt  = s2_len_r;
      end else begin
        load_nxt = s2_dem_r;
        len_nxt  = COST_BITS'(dd_a);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      prev_r    <= '0;
      load_r    <= '0;
      len_r     <= '0;
      cost_r    <= '0;
      sat_r     <= 1'b0;
      ph1_r     <= 1'b0;
      ph2_r     <= 1'b0;
    end else begin
      started_r <= started_nxt;
      prev_r    <= prev_nxt;
      load_r    <= load_nxt;
      len_r     <= len_nxt;
      cost_r    <= cost_nxt;
      sat_r     <= sat_nxt;
      ph1_r     <= is_tour;
      ph2_r     <= ph1_r;
    end
  end

  // Results of the completing item: opening depot, split depot, node, closing depot.
  always_comb begin
    push.mask    = {s2_end_r, ~s2_a_is_d_r, ~s2_a_is_d_r & ~s2_fit_r, s2_start_r}
                 & {RES_SLOTS{ph2_r}};
    push.slot[0] = '{node: s2_d_r, last: 1'b0, cost: '0, sat: 1'b0};
    push.slot[1] = '{node: s2_d_r, last: 1'b0, cost: '0, sat: 1'b0};
    push.slot[2] = '{node: s2_a_r, last: 1'b0, cost: '0, sat: 1'b0};
    push.slot[3] = '{node: s2_d_r, last: 1'b1, cost: cost_new, sat: sat_new};
  end

  assign status.busy      = ph1_r;
  assign status.finishing = ph2_r;

`ifndef SYNTHESIS
  // A tour item always goes through both lookup phases in turn.
  a_phase_seq: assert property (@(posedge clk) disable iff (!rst_n)
    ph1_r |=> (ph2_r && !ph1_r))
    else $error("tour item did not move from first to second phase");

  a_tour_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_op == OP_TOUR)) |=> ph1_r)
    else $error("accepted tour item did not enter the lookup");

  // The second read pair owns both memory ports: no transfer may land then.
  a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !ph1_r)
    else $error("item accepted while second read pair was issued");
`endif

endmodule

`default_nettype wire

// ===== hdl/grs_result_fifo.sv =====
// Result queue: takes up to four results per cycle and releases one per cycle while it is popped.
`timescale 1ns / 1ps
`default_nettype none

module grs_result_fifo import grs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  push_grp_t                push,
  input  logic                     pop,
  output result_t                  head,
  output logic [FIFO_CNT_BITS-1:0] count
);

  result_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_BITS-1:0] count_r;
  logic [SLOT_CNT_BITS-1:0] off [RES_SLOTS];
  logic [SLOT_CNT_BITS-1:0] push_n;

  // Each used slot goes to the next free place, keeping the slot order.
  always_comb begin
    push_n = '0;
    for (int i = 0; i < RES_SLOTS; i++) begin
      off[i] = push_n;
      push_n = push_n + SLOT_CNT_BITS'(push.mask[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_SLOTS; i++) begin
      if (push.mask[i]) begin
        mem[wr_ptr_r + FIFO_PTR_BITS'(off[i])] <= push.slot[i];
      end
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_PTR_BITS'(push_n);
      rd_ptr_r <= rd_ptr_r + FIFO_PTR_BITS'(pop);
      count_r  <= count_r + FIFO_CNT_BITS'(push_n) - FIFO_CNT_BITS'(pop);
    end
  end

  assign head  = mem[rd_ptr_r];
  assign count = count_r;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (FIFO_CNT_BITS+1)'(count_r) + (FIFO_CNT_BITS+1)'(push_n) <= (FIFO_CNT_BITS+1)'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("result queue read while empty");

  a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (!pop && (push_n != '0)) |=> (count_r > $past(count_r)))
    else $error("result queue count did not grow on a push");
`endif

endmodule

`default_nettype wire

// ===== hdl/greedy_route_split.sv =====
// Top level of the greedy route splitter: configuration registers, flow control, queue.
`timescale 1ns / 1ps
`default_nettype none

// Greedy route splitter. Table write items (distance, demand) are written as they are accepted.
// A tour node's four distance lookups are served as two read pairs on the dual-read
// distance memory, with the demand read alongside the first pair, so the input stalls
// while the second pair is issued. Results reach the 16-entry result queue through the
// first- and second-phase registers and leave it at one transfer per cycle while the
// output is not stalled; the input also stalls while the queue, holding four places for
// a node that is being completed, has fewer than four free places. The tables need
// no clearing after reset; reading an entry never written gives an undefined value.
module greedy_route_split import grs_pkg::*; #(
  parameter int NODE_COUNT = 64,
  parameter int DIST_BITS  = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Item channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_op,
  input  logic [NODE_ID_BITS-1:0]  in_node_a,
  input  logic [NODE_ID_BITS-1:0]  in_node_b,
  input  logic [WEIGHT_BITS-1:0]   in_weight,
  input  logic                     in_tour_end,
  // Result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [NODE_ID_BITS-1:0]  out_route_node,
  output logic                     out_run_last,
  output logic [COST_BITS-1:0]     out_total_cost,
  output logic                     out_cost_saturated,
  // Configuration port
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  cfg_t cfg_r, cfg_nxt;

  // Register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEPOT:      cfg_nxt.depot      = cfg_wdata[NODE_ID_BITS-1:0];
        CFG_CAPACITY:   cfg_nxt.capacity   = cfg_wdata[LOAD_BITS-1:0];
        CFG_PATH_LIMIT: cfg_nxt.path_limit = cfg_wdata[COST_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depot      <= DEPOT_RESET;
      cfg_r.capacity   <= CAPACITY_RESET;
      cfg_r.path_limit <= PATH_LIMIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  core_status_t             status;
  push_grp_t                push;
  result_t                  head;
  logic [FIFO_CNT_BITS-1:0] fifo_count;
  logic                     in_acc, pop, queue_full;

  // Room for the results of the completing item and of one more.
  assign queue_full = ((FIFO_CNT_BITS+1)'(fifo_count)
                      + (status.finishing ? (FIFO_CNT_BITS+1)'(RES_SLOTS) : '0))
                      > (FIFO_CNT_BITS+1)'(FIFO_DEPTH - RES_SLOTS);
  assign in_stall   = status.busy || queue_full;
  assign in_acc     = in_valid && !in_stall;
  assign out_valid  = (fifo_count != '0);
  assign pop        = out_valid && !out_stall;

  grs_split_core #(
    .NODE_COUNT (NODE_COUNT),
    .DIST_BITS  (DIST_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_acc      (in_acc),
    .in_op       (in_op),
    .in_node_a   (in_node_a),
    .in_node_b   (in_node_b),
    .in_weight   (in_weight),
    .in_tour_end (in_tour_end),
    .status      (status),
    .push        (push)
  );

  grs_result_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .count (fifo_count)
  );

  assign out_route_node     = head.node;
  assign out_run_last       = head.last;
  assign out_total_cost     = head.cost;
  assign out_cost_saturated = head.sat;

endmodule

`default_nettype wire
